// ----- sv/csem_pkg.sv -----
`default_nettype none
package csem_pkg;

  localparam int CNT_W = 16;

  // request opcodes on the input word
  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_ACQUIRE = 2'd0;
  localparam opcode_t OP_RELEASE = 2'd1;
  localparam opcode_t OP_TRY     = 2'd2;

  // request kind after decode; the unused opcode is carried as a no-op
  typedef enum logic [1:0] {
    KIND_ACQUIRE,
    KIND_RELEASE,
    KIND_TRY,
    KIND_NONE
  } kind_e;

  // result status codes
  typedef logic [2:0] status_t;
  localparam status_t ST_GRANTED    = 3'd0;
  localparam status_t ST_QUEUED     = 3'd1;
  localparam status_t ST_RELEASED   = 3'd2;
  localparam status_t ST_NOT_HOLDER = 3'd3;
  localparam status_t ST_TRY_FAILED = 3'd4;
  localparam status_t ST_FULL       = 3'd5;

  typedef struct packed {
    status_t          status;
    logic             woken_valid;
    logic [7:0]       woken_thread;
    logic [CNT_W-1:0] count_now;
    logic             thread_holds;
    logic             thread_waits;
    logic [4:0]       waiter_count;
  } result_t;

endpackage
`default_nettype wire

// ----- sv/csem_front.sv -----
`default_nettype none
module csem_front import csem_pkg::*; #(
  parameter int ID_BITS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_valid_i,
  output logic                    s_ready_o,
  input  wire opcode_t            s_opcode_i,
  input  wire logic [7:0]         s_thread_i,
  output logic                    req_valid_o,
  output kind_e                   req_kind_o,
  output logic [ID_BITS-1:0]      req_id_o,
  input  wire logic               req_pop_i
);

  kind_e              kind_q [2];
  logic [ID_BITS-1:0] id_q   [2];
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         cnt_q, cnt_d;
  logic               push;
  kind_e              kind_c;
  logic [ID_BITS+7:0] id_ext;

  always_comb begin
    unique case (s_opcode_i)
      OP_ACQUIRE: kind_c = KIND_ACQUIRE;
      OP_RELEASE: kind_c = KIND_RELEASE;
      OP_TRY:     kind_c = KIND_TRY;
      default:    kind_c = KIND_NONE;
    endcase
  end

  // thread id taken modulo 2^ID_BITS
  assign id_ext = {{ID_BITS{1'b0}}, s_thread_i};

  assign s_ready_o   = (cnt_q != 2'd2);
  assign push        = s_valid_i && s_ready_o;
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_kind_o  = kind_q[rd_ptr_q];
  assign req_id_o    = id_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = req_pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, req_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      kind_q[wr_ptr_q] <= kind_c;
      id_q[wr_ptr_q]   <= id_ext[ID_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- sv/csem_back.sv -----
`default_nettype none
module csem_back import csem_pkg::*; #(
  parameter int ID_BITS     = 8,
  parameter int MAX_HOLDERS = 16,
  parameter int WAIT_DEPTH  = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CNT_W-1:0]   cfg_wdata_i,
  input  wire logic               req_valid_i,
  input  wire kind_e              req_kind_i,
  input  wire logic [ID_BITS-1:0] req_id_i,
  output logic                    req_pop_o,
  output logic                    m_valid_o,
  input  wire logic               m_ready_i,
  output result_t                 m_result_o
);

  localparam int HIDX_W = (MAX_HOLDERS > 1) ? $clog2(MAX_HOLDERS) : 1;
  localparam int WIDX_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int FILL_W = $clog2(WAIT_DEPTH + 1);
  localparam int OFF_W  = FILL_W + 1;

  localparam logic ST_LOOK = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                   state_q, state_d;
  kind_e                  kind_q;
  logic [ID_BITS-1:0]     id_q;
  logic [MAX_HOLDERS-1:0] hmatch_q, free_q, hmatch_c;
  logic [WAIT_DEPTH-1:0]  wmatch_q, wmatch_c;

  logic [CNT_W-1:0]       sem_q, sem_d;
  logic [MAX_HOLDERS-1:0] hvalid_q, hvalid_d;
  logic [ID_BITS-1:0]     holder_ids_q [MAX_HOLDERS];
  logic [ID_BITS-1:0]     wait_ids_q   [WAIT_DEPTH];
  logic [WIDX_W-1:0]      head_q, head_d, tail_q, tail_d;
  logic [FILL_W-1:0]      fill_q, fill_d;

  logic                   out_valid_q, out_valid_d;
  result_t                res_q, res_d;

  logic                   pop, exec_go;
  logic                   do_grant, do_queue, do_wake, do_free;
  logic [HIDX_W-1:0]      first_h, first_free;
  logic                   hany, hmulti, free_any, wany, count_nz;
  logic [ID_BITS-1:0]     wid;
  logic [ID_BITS+7:0]     wid_ext;
  logic [FILL_W+4:0]      fill_ext;
  logic [OFF_W-1:0]       off;

  assign pop       = (state_q == ST_LOOK) && req_valid_i;
  assign req_pop_o = pop;
  assign exec_go   = (state_q == ST_EXEC) && (!out_valid_q || m_ready_i);

  // per-lane compare against the holder table and the live part of the queue
  always_comb begin
    for (int i = 0; i < MAX_HOLDERS; i++) begin
      hmatch_c[i] = hvalid_q[i] && (holder_ids_q[i] == req_id_i);
    end
    for (int p = 0; p < WAIT_DEPTH; p++) begin
      if (WIDX_W'(p) >= head_q) begin
        off = OFF_W'(p) - OFF_W'(head_q);
      end else begin
        off = OFF_W'(p) + OFF_W'(WAIT_DEPTH) - OFF_W'(head_q);
      end
      wmatch_c[p] = (off < OFF_W'(fill_q)) && (wait_ids_q[p] == req_id_i);
    end
  end

  always_comb begin
    first_h    = '0;
    first_free = '0;
    for (int i = MAX_HOLDERS - 1; i >= 0; i--) begin
      if (hmatch_q[i]) begin
        first_h = HIDX_W'(i);
      end
      if (free_q[i]) begin
        first_free = HIDX_W'(i);
      end
    end
  end

  assign hany      = |hmatch_q;
  assign hmulti    = |(hmatch_q & (hmatch_q - 1'b1));
  assign free_any  = |free_q;
  assign wany      = |wmatch_q;
  assign count_nz  = (sem_q != '0);
  assign wid       = wait_ids_q[head_q];
  assign wid_ext   = {8'd0, wid};

  always_comb begin
    do_grant = 1'b0;
    do_queue = 1'b0;
    do_wake  = 1'b0;
    do_free  = 1'b0;
    res_d    = '0;
    res_d.status = ST_NOT_HOLDER;
    unique case (kind_q)
      KIND_ACQUIRE: begin
        if (count_nz) begin
          do_grant     = free_any;
          res_d.status = free_any ? ST_GRANTED : ST_FULL;
        end else if (fill_q == FILL_W'(WAIT_DEPTH)) begin
          res_d.status = ST_FULL;
        end else begin
          do_queue     = 1'b1;
          res_d.status = ST_QUEUED;
        end
      end
      KIND_TRY: begin
        if (count_nz) begin
          do_grant     = free_any;
          res_d.status = free_any ? ST_GRANTED : ST_FULL;
        end else begin
          res_d.status = ST_TRY_FAILED;
        end
      end
      KIND_RELEASE: begin
        if (hany) begin
          res_d.status = ST_RELEASED;
          do_wake      = (fill_q != '0);
          do_free      = (fill_q == '0);
        end
      end
      default: res_d.status = ST_NOT_HOLDER;
    endcase

    sem_d    = sem_q;
    hvalid_d = hvalid_q;
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    if (do_grant) begin
      sem_d = sem_q - 1'b1;
      hvalid_d[first_free] = 1'b1;
    end
    if (do_free) begin
      hvalid_d[first_h] = 1'b0;
      if (sem_q != '1) begin
        sem_d = sem_q + 1'b1;
      end
    end
    if (do_queue) begin
      tail_d = (tail_q == WIDX_W'(WAIT_DEPTH - 1)) ? '0 : tail_q + 1'b1;
      fill_d = fill_q + 1'b1;
    end
    if (do_wake) begin
      head_d = (head_q == WIDX_W'(WAIT_DEPTH - 1)) ? '0 : head_q + 1'b1;
      fill_d = fill_q - 1'b1;
    end

    fill_ext           = {5'd0, fill_d};
    res_d.count_now    = sem_d;
    res_d.waiter_count = fill_ext[4:0];
    res_d.woken_valid  = do_wake;
    res_d.woken_thread = do_wake ? wid_ext[7:0] : 8'd0;
    res_d.thread_holds = hany;
    res_d.thread_waits = wany;
    if (do_grant) begin
      res_d.thread_holds = 1'b1;
    end
    if (do_queue) begin
      res_d.thread_waits = 1'b1;
    end
    if (do_free) begin
      res_d.thread_holds = hmulti;
    end
    if (do_wake) begin
      res_d.thread_holds = hmulti || (wid == id_q);
      res_d.thread_waits = |(wmatch_q & ~(WAIT_DEPTH'(1) << head_q));
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOOK: if (pop) state_d = ST_EXEC;
      ST_EXEC: if (exec_go) state_d = ST_LOOK;
      default: state_d = ST_LOOK;
    endcase
    out_valid_d = exec_go ? 1'b1 : (m_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOOK;
      sem_q       <= CNT_W'(1);
      hvalid_q    <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      // config must arrive only while idle so it never collides with a request; the block does not enforce it
      if (cfg_we_i) begin
        sem_q <= cfg_wdata_i;
      end else if (exec_go) begin
        sem_q <= sem_d;
      end
      if (exec_go) begin
        hvalid_q <= hvalid_d;
        head_q   <= head_d;
        tail_q   <= tail_d;
        fill_q   <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      kind_q   <= req_kind_i;
      id_q     <= req_id_i;
      hmatch_q <= hmatch_c;
      free_q   <= ~hvalid_q;
      wmatch_q <= wmatch_c;
    end
    if (exec_go) begin
      res_q <= res_d;
      if (do_grant) begin
        holder_ids_q[first_free] <= id_q;
      end
      if (do_wake) begin
        holder_ids_q[first_h] <= wid;
      end
      if (do_queue) begin
        wait_ids_q[tail_q] <= id_q;
      end
    end
  end

  assign m_valid_o  = out_valid_q;
  assign m_result_o = res_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(WAIT_DEPTH))
    else $error("wait queue fill past depth");

  a_out_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EXEC))
    else $error("result appeared without an executed request");

  a_woken_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.woken_valid) |-> (res_q.status == ST_RELEASED))
    else $error("wake reported on a non-release");

  a_pop_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (state_q == ST_EXEC))
    else $error("popped request not executed next");

endmodule
`default_nettype wire

// ----- sv/counting_semaphore_with_wait_queue.sv -----
// Counting semaphore with a holder table and a FIFO wait queue. Each request word names a
// thread and an operation (acquire, release, try-acquire) and produces exactly one result
// word with the status, the woken waiter on a release, the count and the waiter count
// afterwards, and whether the requester now holds or waits. A two-word input queue decodes
// requests ahead of the executing part, which handles each request in a look step that
// compares the id against every holder and live queue entry, then an execute step that
// updates the tables and registers the result. No request is taken before the last one
// has executed, and execution waits for the result register to drain. Writing cfg_wdata_i
// reloads the count but not the tables; after reset the count is 1, with no clearing pass.
`default_nettype none
module counting_semaphore_with_wait_queue import csem_pkg::*; #(
  parameter int ID_BITS     = 8,
  parameter int MAX_HOLDERS = 16,
  parameter int WAIT_DEPTH  = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CNT_W-1:0]  cfg_wdata_i,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // opcode[1:0], thread_id[9:2], zero pad[15:10]
  input  wire logic [15:0]       s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // status[2:0], woken_valid[3], woken_thread[11:4], count_now[27:12],
  // thread_holds[28], thread_waits[29], waiter_count[34:30], zero pad[39:35]
  output logic [39:0]            m_axis_tdata
);

  logic               req_valid, req_pop;
  kind_e              req_kind;
  logic [ID_BITS-1:0] req_id;
  result_t            res;

  csem_front #(
    .ID_BITS (ID_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_opcode_i  (s_axis_tdata[1:0]),
    .s_thread_i  (s_axis_tdata[9:2]),
    .req_valid_o (req_valid),
    .req_kind_o  (req_kind),
    .req_id_o    (req_id),
    .req_pop_i   (req_pop)
  );

  csem_back #(
    .ID_BITS     (ID_BITS),
    .MAX_HOLDERS (MAX_HOLDERS),
    .WAIT_DEPTH  (WAIT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_valid_i (req_valid),
    .req_kind_i  (req_kind),
    .req_id_i    (req_id),
    .req_pop_o   (req_pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_result_o  (res)
  );

  assign m_axis_tdata = {5'd0, res.waiter_count, res.thread_waits, res.thread_holds,
                         res.count_now, res.woken_thread, res.woken_valid, res.status};

endmodule
`default_nettype wire

// ----- verif/counting_semaphore_with_wait_queue_checker.sv -----
`timescale 1ns / 1ps
module counting_semaphore_with_wait_queue_checker
  import csem_pkg::*;
#(
  parameter int MAX_HOLDERS = 16,
  parameter int WAIT_DEPTH  = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  // opcode[1:0], thread_id[9:2], zero pad[15:10]
  input  logic [15:0]      s_axis_tdata,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // status[2:0], woken_valid[3], woken_thread[11:4], count_now[27:12],
  // thread_holds[28], thread_waits[29], waiter_count[34:30], zero pad[39:35]
  input  logic [39:0]      m_axis_tdata,
  output int               error_count_o,
  output int               replies_owed_o
);

  // shadow copy of the semaphore
  logic [CNT_W-1:0] sem_count;
  logic [7:0]       holder_id   [MAX_HOLDERS];
  logic             holder_used [MAX_HOLDERS];
  logic [7:0]       wait_id     [WAIT_DEPTH];
  int               wait_head;
  int               wait_tail;
  int               wait_fill;

  result_t reply_q [$];
  result_t want;
  result_t seen;
  int      reply_index;

  task automatic report_mismatch(string fld, logic [31:0] got, logic [31:0] exp_val);
    error_count_o++;
    $display("%0t: reply %0d %s got 0x%0h expected 0x%0h", $time, reply_index, fld, got,
             exp_val);
  endtask

  function automatic int holder_slot(logic [7:0] id);
    for (int i = 0; i < MAX_HOLDERS; i++)
      if (holder_used[i] && holder_id[i] == id) return i;
    return -1;
  endfunction

  // lowest free holder entry takes the thread
  function automatic status_t take_slot(logic [7:0] id);
    for (int i = 0; i < MAX_HOLDERS; i++) begin
      if (!holder_used[i]) begin
        holder_id[i]   = id;
        holder_used[i] = 1'b1;
        sem_count      = sem_count - 1'b1;
        return ST_GRANTED;
      end
    end
    return ST_FULL;
  endfunction

  function automatic result_t serve_request(opcode_t op, logic [7:0] id);
    result_t r;
    int      slot;
    r = '0;
    r.status = ST_NOT_HOLDER;
    if (op == OP_ACQUIRE) begin
      if (sem_count != 0) begin
        r.status = take_slot(id);
      end else if (wait_fill >= WAIT_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        wait_id[wait_tail] = id;
        wait_tail = (wait_tail + 1) % WAIT_DEPTH;
        wait_fill++;
        r.status = ST_QUEUED;
      end
    end else if (op == OP_TRY) begin
      r.status = (sem_count != 0) ? take_slot(id) : ST_TRY_FAILED;
    end else if (op == OP_RELEASE) begin
      slot = holder_slot(id);
      if (slot >= 0) begin
        r.status = ST_RELEASED;
        if (wait_fill > 0) begin
          // head waiter inherits the slot, count unchanged
          r.woken_valid     = 1'b1;
          r.woken_thread    = wait_id[wait_head];
          holder_id[slot]   = wait_id[wait_head];
          wait_head         = (wait_head + 1) % WAIT_DEPTH;
          wait_fill--;
        end else begin
          holder_used[slot] = 1'b0;
          if (sem_count != '1) sem_count = sem_count + 1'b1;
        end
      end
    end
    r.count_now    = sem_count;
    r.thread_holds = (holder_slot(id) >= 0);
    r.thread_waits = 1'b0;
    for (int k = 0; k < wait_fill; k++)
      if (wait_id[(wait_head + k) % WAIT_DEPTH] == id) r.thread_waits = 1'b1;
    r.waiter_count = 5'(wait_fill);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sem_count = 16'd1;
      for (int i = 0; i < MAX_HOLDERS; i++) holder_used[i] = 1'b0;
      wait_head      = 0;
      wait_tail      = 0;
      wait_fill      = 0;
      reply_index    = 0;
      error_count_o  = 0;
      replies_owed_o = 0;
      reply_q.delete();
    end else begin
      // retire first so a stray word is never matched against a same-cycle request
      if (m_axis_tvalid && m_axis_tready) begin
        if (reply_q.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata[31:0], '0);
        end else begin
          want = reply_q.pop_front();
          seen.status       = m_axis_tdata[2:0];
          seen.woken_valid  = m_axis_tdata[3];
          seen.woken_thread = m_axis_tdata[11:4];
          seen.count_now    = m_axis_tdata[27:12];
          seen.thread_holds = m_axis_tdata[28];
          seen.thread_waits = m_axis_tdata[29];
          seen.waiter_count = m_axis_tdata[34:30];
          if (seen.status !== want.status)
            report_mismatch("status", 32'(seen.status), 32'(want.status));
          if (seen.woken_valid !== want.woken_valid)
            report_mismatch("woken_valid", 32'(seen.woken_valid), 32'(want.woken_valid));
          if (seen.woken_thread !== want.woken_thread)
            report_mismatch("woken_thread", 32'(seen.woken_thread), 32'(want.woken_thread));
          if (seen.count_now !== want.count_now)
            report_mismatch("count_now", 32'(seen.count_now), 32'(want.count_now));
          if (seen.thread_holds !== want.thread_holds)
            report_mismatch("thread_holds", 32'(seen.thread_holds), 32'(want.thread_holds));
          if (seen.thread_waits !== want.thread_waits)
            report_mismatch("thread_waits", 32'(seen.thread_waits), 32'(want.thread_waits));
          if (seen.waiter_count !== want.waiter_count)
            report_mismatch("waiter_count", 32'(seen.waiter_count), 32'(want.waiter_count));
          if (m_axis_tdata[39:35] !== '0)
            report_mismatch("zero pad", 32'(m_axis_tdata[39:35]), '0);
        end
        reply_index++;
      end
      if (cfg_we_i) sem_count = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        reply_q.push_back(serve_request(s_axis_tdata[1:0], s_axis_tdata[9:2]));
      replies_owed_o = reply_q.size();
    end
  end

endmodule

// ----- verif/counting_semaphore_with_wait_queue_tb.sv -----
`timescale 1ns / 1ps
module counting_semaphore_with_wait_queue_tb;
  import csem_pkg::*;

  localparam opcode_t OP_UNUSED   = 2'd3;
  localparam int      STALL_LIMIT = 2000;
  localparam int      PHASES      = 10;
  localparam int      PHASE_ITEMS = 125;
  localparam int      CROWD_ITEMS = 20;

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             cfg_we        = 1'b0;
  logic [CNT_W-1:0] cfg_wdata     = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [15:0]      s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [39:0]      m_axis_tdata;

  int         error_count;
  int         replies_owed;
  int         stall_cycles = 0;
  int         hold_len     = 0;
  bit         quiet        = 1'b0;
  logic [7:0] pool [8];

  counting_semaphore_with_wait_queue u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  counting_semaphore_with_wait_queue_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .error_count_o  (error_count),
    .replies_owed_o (replies_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random backpressure, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      m_axis_tready <= quiet || ($urandom_range(99) >= 31);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("counting_semaphore_with_wait_queue_tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_request(opcode_t op, logic [7:0] id);
    while (!quiet && $urandom_range(99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, id, op};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // stop offering words until every reply is back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    wait (replies_owed == 0);
    @(posedge clk);
  endtask

  task automatic load_count(logic [CNT_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_requests(int n);
    int      pick;
    opcode_t op;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 38)      op = OP_ACQUIRE;
      else if (pick < 78) op = OP_RELEASE;
      else if (pick < 95) op = OP_TRY;
      else                op = OP_UNUSED;
      // mostly a small set of threads so releases find holders
      if ($urandom_range(99) < 75) send_request(op, pool[$urandom_range(7)]);
      else                         send_request(op, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    logic [CNT_W-1:0] phase_count [PHASES];
    phase_count = '{16'd0, 16'hFFFF, 16'd3, 16'd0, 16'd20, 16'd1, 16'd0, 16'hFFFE, 16'd0,
                    16'd2};
    phase_count[6] = CNT_W'($urandom_range(65535));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // count starts at one
    send_request(OP_ACQUIRE, 8'h00);
    send_request(OP_TRY,     8'hFF);
    send_request(OP_ACQUIRE, 8'hFF);
    send_request(OP_ACQUIRE, 8'hAA);
    send_request(OP_RELEASE, 8'h55);
    send_request(OP_UNUSED,  8'h00);
    send_request(OP_RELEASE, 8'h00);
    send_request(OP_RELEASE, 8'hFF);
    send_request(OP_RELEASE, 8'hAA);
    // one thread both holding and waiting
    send_request(OP_ACQUIRE, 8'hAA);
    send_request(OP_ACQUIRE, 8'hAA);
    send_request(OP_RELEASE, 8'hAA);
    send_request(OP_TRY,     8'h01);
    // release at the top of the range saturates
    load_count(16'hFFFF);
    send_request(OP_RELEASE, 8'hAA);
    send_request(OP_TRY,     8'h01);
    send_request(OP_RELEASE, 8'h01);

    for (int p = 0; p < PHASES; p++) begin
      load_count(phase_count[p]);
      quiet = (p == 2);
      foreach (pool[k]) pool[k] = 8'($urandom_range(255));
      if (p == 4) hold_len = 150;
      // acquire burst fills the holder table or the wait queue
      for (int i = 0; i < CROWD_ITEMS; i++) send_request(OP_ACQUIRE, pool[$urandom_range(7)]);
      random_requests(PHASE_ITEMS - CROWD_ITEMS);
    end
    quiet = 1'b0;

    settle();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("counting_semaphore_with_wait_queue_tb OK");
    end else begin
      $display("counting_semaphore_with_wait_queue_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/csem_pkg.sv
sv/csem_front.sv
sv/csem_back.sv
sv/counting_semaphore_with_wait_queue.sv
verif/counting_semaphore_with_wait_queue_checker.sv
verif/counting_semaphore_with_wait_queue_tb.sv
